// ===== rtl/mm_ss_clock_with_set_mode_defines.svh =====
// Assertion macros for the minutes:seconds clock block.
`ifndef MM_SS_CLOCK_WITH_SET_MODE_DEFINES_SVH
`define MM_SS_CLOCK_WITH_SET_MODE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define MMCS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mmcs assertion failed");

// Antecedent implies consequent in the same cycle.
`define MMCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmcs assertion failed");

`endif

// ===== rtl/mmcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmcs_pkg;

    localparam logic [7:0] TICKS_RESET  = 8'd16;
    localparam logic [5:0] FIELD_LIMIT  = 6'd60;
    localparam logic [7:0] SEG_BLANK    = 8'hFF;
    localparam logic [7:0] SEG_DOT_MASK = 8'h7F;

    localparam logic [1:0] MODE_RUN     = 2'd0;
    localparam logic [1:0] MODE_SET_MIN = 2'd1;
    localparam logic [1:0] MODE_SET_SEC = 2'd2;

    typedef enum logic [2:0] {
        PH_RUN      = 3'd0,
        PH_REL_A    = 3'd1,
        PH_SET_MIN  = 3'd2,
        PH_MIN_HELD = 3'd3,
        PH_REL_B    = 3'd4,
        PH_SET_SEC  = 3'd5,
        PH_SEC_HELD = 3'd6,
        PH_REL_C    = 3'd7
    } t_phase;

    typedef struct packed {
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] mode;
    } t_clk_state;

    typedef struct packed {
        logic [7:0] min_tens;
        logic [7:0] min_ones;
        logic [7:0] sec_tens;
        logic [7:0] sec_ones;
    } t_seg_view;

    function automatic logic [1:0] mode_of(input t_phase ph);
        logic [1:0] m;
        case (ph)
            PH_RUN, PH_REL_A:                    m = MODE_RUN;
            PH_SET_MIN, PH_MIN_HELD, PH_REL_B:   m = MODE_SET_MIN;
            default:                             m = MODE_SET_SEC;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hD8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Tens digit of a value 0..59.
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50)      t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [5:0] wrap_inc(input logic [5:0] v);
        logic [5:0] n;
        n = v + 6'd1;
        return (n >= FIELD_LIMIT) ? 6'd0 : n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mmcs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmcs_core import mmcs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic       i_tick,
    input  wire logic       i_enter,
    input  wire logic       i_plus,
    input  wire logic [7:0] i_ticks_per_sec,
    output t_clk_state      o_next
);

    t_phase     r_phase, n_phase;
    logic [5:0] r_minutes, n_minutes;
    logic [5:0] r_seconds, n_seconds;
    logic [7:0] r_prescale, n_prescale;

    logic w_inc_min, w_inc_sec, w_do_tick;
    logic [7:0] w_pre_dec;

    // next phase; release waits fall through into the following phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_RUN:      if (i_enter) n_phase = PH_REL_A;
            PH_REL_A:    if (!i_enter) n_phase = i_plus ? PH_MIN_HELD : PH_SET_MIN;
            PH_SET_MIN: begin
                if (i_enter)     n_phase = PH_REL_B;
                else if (i_plus) n_phase = PH_MIN_HELD;
            end
            PH_MIN_HELD: if (!i_plus) n_phase = i_enter ? PH_REL_B : PH_SET_MIN;
            PH_REL_B:    if (!i_enter) n_phase = i_plus ? PH_SEC_HELD : PH_SET_SEC;
            PH_SET_SEC: begin
                if (i_enter)     n_phase = PH_REL_C;
                else if (i_plus) n_phase = PH_SEC_HELD;
            end
            PH_SEC_HELD: if (!i_plus) n_phase = i_enter ? PH_REL_C : PH_SET_SEC;
            PH_REL_C:    if (!i_enter) n_phase = PH_RUN;
            default:     n_phase = PH_RUN;
        endcase
    end

    always_comb begin
        w_inc_min = 1'b0;
        w_inc_sec = 1'b0;
        w_do_tick = 1'b0;
        case (r_phase)
            PH_RUN:     w_do_tick = !i_enter && i_tick;
            PH_REL_A:   w_inc_min = !i_enter && i_plus;
            PH_SET_MIN: w_inc_min = !i_enter && i_plus;
            PH_REL_B:   w_inc_sec = !i_enter && i_plus;
            PH_SET_SEC: w_inc_sec = !i_enter && i_plus;
            PH_REL_C:   w_do_tick = !i_enter && i_tick;
            default: begin
                w_inc_min = 1'b0;
                w_inc_sec = 1'b0;
                w_do_tick = 1'b0;
            end
        endcase
    end

    assign w_pre_dec = r_prescale - 8'd1;

    always_comb begin
        n_prescale = r_prescale;
        n_seconds  = r_seconds;
        n_minutes  = r_minutes;
        if (w_do_tick) begin
            n_prescale = w_pre_dec;
            if (w_pre_dec == 8'd0) begin
                n_prescale = i_ticks_per_sec;
                n_seconds  = wrap_inc(r_seconds);
                if (r_seconds == FIELD_LIMIT - 6'd1) n_minutes = wrap_inc(r_minutes);
            end
        end
        if (w_inc_min) n_minutes = wrap_inc(r_minutes);
        if (w_inc_sec) n_seconds = wrap_inc(r_seconds);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RUN;
            r_minutes  <= 6'd0;
            r_seconds  <= 6'd0;
            r_prescale <= TICKS_RESET;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_minutes  <= n_minutes;
            r_seconds  <= n_seconds;
            r_prescale <= n_prescale;
        end
    end

    assign o_next.minutes = n_minutes;
    assign o_next.seconds = n_seconds;
    assign o_next.mode    = mode_of(n_phase);

endmodule

`default_nettype wire

// ===== rtl/mmcs_disp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmcs_disp import mmcs_pkg::*; (
    input  t_clk_state i_state,
    output t_seg_view  o_view
);

    logic [2:0] w_sec_t, w_min_t;
    logic [5:0] w_sec_o, w_min_o;
    logic [7:0] w_sec_seg, w_min_seg;

    assign w_sec_t = tens_of(i_state.seconds);
    assign w_min_t = tens_of(i_state.minutes);
    assign w_sec_o = i_state.seconds - 6'({3'd0, w_sec_t} * 6'd10);
    assign w_min_o = i_state.minutes - 6'({3'd0, w_min_t} * 6'd10);

    assign w_sec_seg = digit_seg(w_sec_o[3:0]);
    assign w_min_seg = digit_seg(w_min_o[3:0]);

    assign o_view.sec_ones = (i_state.mode == MODE_SET_SEC) ? (w_sec_seg & SEG_DOT_MASK)
                                                            : w_sec_seg;
    assign o_view.min_ones = (i_state.mode == MODE_SET_MIN) ? (w_min_seg & SEG_DOT_MASK)
                                                            : w_min_seg;
    assign o_view.sec_tens = digit_seg({1'b0, w_sec_t});
    assign o_view.min_tens = digit_seg({1'b0, w_min_t});

endmodule

`default_nettype wire

// ===== rtl/mm_ss_clock_with_set_mode.sv =====
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tick, enter_pressed, plus_pressed
// m_axis    out  m_axis_tvalid/tready      segments, minutes, seconds, mode
// apb       in   psel/penable/pwrite       ticks_per_second at address 0
//
// One transaction per cycle sustained while m_axis is ready; two register stages
// (input register, then result register after the clock state step and segment
// decode); a result is valid on m_axis once it has passed both registers in turn.
// While a result waits on m_axis the input stage takes one more transaction.
// Synchronous active-low reset: clock 00:00, running, prescaler and register 16.
// A stall on m_axis backs up through the input stage; no transaction is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "mm_ss_clock_with_set_mode_defines.svh"

module mm_ss_clock_with_set_mode import mmcs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] tick, [1] enter_pressed, [2] plus_pressed, [7:3] zero
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] seg_sec_ones, [15:8] seg_sec_tens, [23:16] seg_min_ones,
    // [31:24] seg_min_tens, [37:32] minutes_now, [43:38] seconds_now,
    // [45:44] display_mode, [47:46] zero
    output logic [47:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       r_s1_valid;
    logic [2:0] r_s1_data;
    logic       r_o_valid;
    logic [47:0] r_o_data;
    logic [7:0] r_ticks;

    logic       w_o_ready, w_s1_adv;
    t_clk_state w_next;
    t_seg_view  w_view;

    assign w_o_ready     = !r_o_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_o_ready;
    assign s_axis_tready = !r_s1_valid || w_o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_data <= s_axis_tdata[2:0];
        end
    end

    mmcs_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_s1_adv),
        .i_tick          (r_s1_data[0]),
        .i_enter         (r_s1_data[1]),
        .i_plus          (r_s1_data[2]),
        .i_ticks_per_sec (r_ticks),
        .o_next          (w_next)
    );

    mmcs_disp u_disp (
        .i_state (w_next),
        .o_view  (w_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_o_data <= {2'b00, w_next.mode, w_next.seconds, w_next.minutes,
                         w_view.min_tens, w_view.min_ones,
                         w_view.sec_tens, w_view.sec_ones};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_ticks <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_ticks};

    `MMCS_ASSERT_IMPL(a_stall_full, !s_axis_tready, r_s1_valid && r_o_valid)
    `MMCS_ASSERT_IMPL(a_time_range, m_axis_tvalid,
        (m_axis_tdata[37:32] < 6'd60) && (m_axis_tdata[43:38] < 6'd60))
    `MMCS_ASSERT_IMPL(a_mode_code, m_axis_tvalid, m_axis_tdata[45:44] != 2'b11)
    `MMCS_ASSERT_IMPL(a_one_dot, m_axis_tvalid, m_axis_tdata[7] || m_axis_tdata[23])

endmodule

`default_nettype wire
